// File: design/tgc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tgc_pkg;

    // Gesture event codes carried on the result tuser
    typedef enum logic [2:0] {
        EV_CLICK  = 3'd0,
        EV_DOUBLE = 3'd1,
        EV_DOWN   = 3'd2,
        EV_UP     = 3'd3,
        EV_MOVE   = 3'd4
    } t_event_code;

    // Configuration register indexes
    localparam logic [2:0] CFG_HOLD_TICKS   = 3'd0;
    localparam logic [2:0] CFG_SECOND_WIN   = 3'd1;
    localparam logic [2:0] CFG_MIN_GAP      = 3'd2;
    localparam logic [2:0] CFG_MOVE_THRESH  = 3'd3;
    localparam logic [2:0] CFG_LOCKOUT      = 3'd4;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;
    localparam int TICK_W     = 10;
    localparam int EVENT_W    = 3;

    // Register reset values
    localparam logic [7:0] HOLD_RST    = 8'd40;
    localparam logic [7:0] SECOND_RST  = 8'd60;
    localparam logic [7:0] MIN_GAP_RST = 8'd10;
    localparam logic [9:0] THRESH_RST  = 10'd25;
    localparam logic [9:0] LOCKOUT_RST = 10'd100;

endpackage

`default_nettype wire

// File: design/touch_gesture_classifier.sv
`timescale 1ns / 1ps
`default_nettype none

// Touch gesture classifier.
// Slave channel: one touch sample per request; tuser carries pen_up, tdata
// carries sample_x and sample_y. Master channel: one gesture event per
// request; tuser carries event_code, tdata carries event_x and event_y.
// Samples that cause no event produce nothing on the master side.
// Configuration: a write with i_cfg_wr_en high updates register i_cfg_idx
// at the clock edge (0 hold, 1 second window, 2 min gap, 3 move threshold,
// 4 lockout); other indexes are ignored. Write only while the block is idle.
// An accepted sample waits in the input register, is classified into the
// result register, and its event is visible on the master side from there.
// Throughput: one sample per cycle while the result can move; the gesture state,
// tick counter and compares all settle between the input and result registers.
// Reset clears the gesture state, both valid flags and loads the register
// defaults. When the receiver stalls, the pending event holds in the result
// register; one more sample is taken into the input register and then
// s_axis_tready drops until the event is taken.
module touch_gesture_classifier
    import tgc_pkg::*;
#(
    parameter int COORD_BITS = 10
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    // sample request
    input  wire                                  s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire  [((2*COORD_BITS+7)/8)*8-1:0]    s_axis_tdata,   // sample_x, sample_y
    input  wire                                  s_axis_tuser,   // pen_up
    // event request
    output logic                                 m_axis_tvalid,
    input  wire                                  m_axis_tready,
    output logic [((2*COORD_BITS+7)/8)*8-1:0]    m_axis_tdata,   // event_x, event_y
    output logic [EVENT_W-1:0]                   m_axis_tuser,   // event_code
    // configuration writes
    input  wire                                  i_cfg_wr_en,
    input  wire  [CFG_IDX_W-1:0]                 i_cfg_idx,
    input  wire  [CFG_DATA_W-1:0]                i_cfg_wdata
);

    localparam int DATA_W = ((2 * COORD_BITS + 7) / 8) * 8;
    localparam int PAD_W  = DATA_W - 2 * COORD_BITS;
    localparam int CMP_W  = (COORD_BITS > CFG_DATA_W) ? COORD_BITS : CFG_DATA_W;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_PRESSED,
        PH_RELEASED,
        PH_LOCKOUT,
        PH_DRAG
    } t_phase;

    // Configuration registers
    logic [7:0] r_hold_ticks;
    logic [7:0] r_second_ticks;
    logic [7:0] r_min_gap_ticks;
    logic [9:0] r_move_thresh;
    logic [9:0] r_lockout_ticks;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_ticks    <= HOLD_RST;
            r_second_ticks  <= SECOND_RST;
            r_min_gap_ticks <= MIN_GAP_RST;
            r_move_thresh   <= THRESH_RST;
            r_lockout_ticks <= LOCKOUT_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                CFG_HOLD_TICKS:  r_hold_ticks    <= i_cfg_wdata[7:0];
                CFG_SECOND_WIN:  r_second_ticks  <= i_cfg_wdata[7:0];
                CFG_MIN_GAP:     r_min_gap_ticks <= i_cfg_wdata[7:0];
                CFG_MOVE_THRESH: r_move_thresh   <= i_cfg_wdata;
                CFG_LOCKOUT:     r_lockout_ticks <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Input register
    logic                  r_in_valid;
    logic                  r_in_pen_up;
    logic [COORD_BITS-1:0] r_in_x;
    logic [COORD_BITS-1:0] r_in_y;

    logic r_out_valid;
    logic w_advance;

    assign w_advance     = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_pen_up <= s_axis_tuser;
            r_in_x      <= s_axis_tdata[COORD_BITS-1:0];
            r_in_y      <= s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
        end
    end

    // Gesture state
    t_phase                r_phase, n_phase;
    logic [TICK_W-1:0]     r_tick, n_tick;
    logic [COORD_BITS-1:0] r_ref_x, n_ref_x;
    logic [COORD_BITS-1:0] r_ref_y, n_ref_y;
    logic [COORD_BITS-1:0] r_out_x, n_out_x;
    logic [COORD_BITS-1:0] r_out_y, n_out_y;
    t_event_code           r_out_code, n_out_code;
    logic                  n_emit;

    logic [TICK_W-1:0]     w_tick_inc;
    logic [COORD_BITS-1:0] w_dist_x;
    logic [COORD_BITS-1:0] w_dist_y;
    logic                  w_moved;

    assign w_tick_inc = r_tick + TICK_W'(1);
    assign w_dist_x   = (r_ref_x > r_in_x) ? (r_ref_x - r_in_x) : (r_in_x - r_ref_x);
    assign w_dist_y   = (r_ref_y > r_in_y) ? (r_ref_y - r_in_y) : (r_in_y - r_ref_y);
    assign w_moved    = (CMP_W'(w_dist_x) > CMP_W'(r_move_thresh))
                     || (CMP_W'(w_dist_y) > CMP_W'(r_move_thresh));

    // Classify the registered sample
    always_comb begin
        n_phase    = r_phase;
        n_tick     = r_tick;
        n_ref_x    = r_ref_x;
        n_ref_y    = r_ref_y;
        n_emit     = 1'b0;
        n_out_code = EV_CLICK;
        n_out_x    = r_ref_x;
        n_out_y    = r_ref_y;
        case (r_phase)
            PH_PRESSED: begin
                if (r_in_pen_up) begin
                    n_tick = TICK_W'(1);
                    if (r_second_ticks <= 8'd1) begin
                        n_phase = PH_IDLE;
                        n_emit  = 1'b1;
                    end else begin
                        n_phase = PH_RELEASED;
                    end
                end else begin
                    n_tick = w_tick_inc;
                    if (w_tick_inc >= TICK_W'(r_hold_ticks)) begin
                        n_phase    = PH_DRAG;
                        n_emit     = 1'b1;
                        n_out_code = EV_DOWN;
                    end
                end
            end
            PH_RELEASED: begin
                if (!r_in_pen_up) begin
                    n_emit = 1'b1;
                    if (r_tick < TICK_W'(r_min_gap_ticks)) begin
                        n_phase = PH_IDLE;
                    end else begin
                        n_tick     = '0;
                        n_out_code = EV_DOUBLE;
                        n_phase    = (r_lockout_ticks == '0) ? PH_IDLE : PH_LOCKOUT;
                    end
                end else begin
                    n_tick = w_tick_inc;
                    if (w_tick_inc >= TICK_W'(r_second_ticks)) begin
                        n_phase = PH_IDLE;
                        n_emit  = 1'b1;
                    end
                end
            end
            PH_LOCKOUT: begin
                n_tick = w_tick_inc;
                if (w_tick_inc >= r_lockout_ticks) begin
                    n_phase = PH_IDLE;
                end
            end
            PH_DRAG: begin
                n_out_x = r_in_x;
                n_out_y = r_in_y;
                if (r_in_pen_up) begin
                    n_phase    = PH_IDLE;
                    n_ref_x    = r_in_x;
                    n_ref_y    = r_in_y;
                    n_emit     = 1'b1;
                    n_out_code = EV_UP;
                end else if (w_moved) begin
                    n_ref_x    = r_in_x;
                    n_ref_y    = r_in_y;
                    n_emit     = 1'b1;
                    n_out_code = EV_MOVE;
                end
            end
            default: begin
                n_phase = PH_IDLE;
                if (!r_in_pen_up) begin
                    n_ref_x = r_in_x;
                    n_ref_y = r_in_y;
                    n_out_x = r_in_x;
                    n_out_y = r_in_y;
                    n_tick  = TICK_W'(1);
                    if (r_hold_ticks <= 8'd1) begin
                        n_phase    = PH_DRAG;
                        n_emit     = 1'b1;
                        n_out_code = EV_DOWN;
                    end else begin
                        n_phase = PH_PRESSED;
                    end
                end
            end
        endcase
    end

    // Hold state and the result register; advance only when the result can move
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_tick      <= '0;
            r_ref_x     <= '0;
            r_ref_y     <= '0;
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid && n_emit;
            if (r_in_valid) begin
                r_phase    <= n_phase;
                r_tick     <= n_tick;
                r_ref_x    <= n_ref_x;
                r_ref_y    <= n_ref_y;
                r_out_code <= n_out_code;
                r_out_x    <= n_out_x;
                r_out_y    <= n_out_y;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_code;
    generate
        if (PAD_W > 0) begin : g_pad
            assign m_axis_tdata = {{PAD_W{1'b0}}, r_out_y, r_out_x};
        end else begin : g_nopad
            assign m_axis_tdata = {r_out_y, r_out_x};
        end
    endgenerate

endmodule

`default_nettype wire

// File: design/tgc_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module tgc_checker
    import tgc_pkg::*;
#(
    parameter int COORD_BITS = 10
) (
    input wire                                    i_clk,
    input wire                                    i_rst_n,
    input wire                                    s_axis_tready,
    input wire                                    m_axis_tvalid,
    input wire                                    m_axis_tready,
    input wire [((2*COORD_BITS+7)/8)*8-1:0]       m_axis_tdata,
    input wire [EVENT_W-1:0]                      m_axis_tuser
);

    // A stalled event holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled event changed");

    // Only defined event codes leave the block
    a_code_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tuser <= EVENT_W'(EV_MOVE))
        else $error("undefined event code");

    // Reset leaves no event pending
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("event pending after reset");

    // With no event pending the sample side is always open
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("sample side blocked with no event pending");

endmodule

bind touch_gesture_classifier tgc_checker #(.COORD_BITS(COORD_BITS)) u_tgc_checker (.*);

`default_nettype wire

// File: tb/gesture_checker.sv
`timescale 1ns / 1ps

// Watches the sample, event and configuration channels, predicts the gesture
// events from every accepted sample and compares them with what comes out.
module gesture_checker
    import tgc_pkg::*;
#(
    parameter int COORD_W = 10,
    parameter int DATA_W  = 24
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    // sample request
    input  wire                   i_smp_valid,
    input  wire                   i_smp_ready,
    input  wire  [DATA_W-1:0]     i_smp_data,    // sample_x, sample_y
    input  wire                   i_smp_pen_up,  // pen_up
    // event request
    input  wire                   i_evt_valid,
    input  wire                   i_evt_ready,
    input  wire  [DATA_W-1:0]     i_evt_data,    // event_x, event_y
    input  wire  [EVENT_W-1:0]    i_evt_code,    // event_code
    // configuration writes
    input  wire                   i_cfg_wr_en,
    input  wire  [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire  [CFG_DATA_W-1:0] i_cfg_wdata,
    output int                    o_mismatches,
    output int                    o_pending
);

    typedef enum logic [2:0] {
        GS_IDLE,
        GS_PRESSED,
        GS_RELEASED,
        GS_LOCKOUT,
        GS_DRAG
    } t_gesture_state;

    typedef struct packed {
        t_event_code        code;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } t_gesture_event;

    t_gesture_state     gstate;
    logic [TICK_W-1:0]  tick_cnt;
    logic [COORD_W-1:0] anchor_x;
    logic [COORD_W-1:0] anchor_y;

    logic [7:0]         hold_lim;
    logic [7:0]         window_lim;
    logic [7:0]         min_gap;
    logic [9:0]         move_thresh;
    logic [9:0]         lockout_lim;

    t_gesture_event     expected_events[$];

    function automatic logic [COORD_W-1:0] axis_dist(input logic [COORD_W-1:0] a,
                                                      input logic [COORD_W-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic t_gesture_event make_event(input t_event_code code,
                                                  input logic [COORD_W-1:0] x,
                                                  input logic [COORD_W-1:0] y);
        t_gesture_event ev;
        ev.code = code;
        ev.x    = x;
        ev.y    = y;
        return ev;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] event check: %s", $time, what);
        o_mismatches++;
    endtask

    // Advance the gesture state by one sample; flag the event it produces
    task automatic classify_sample(input logic pen_up,
                                   input logic [COORD_W-1:0] sx,
                                   input logic [COORD_W-1:0] sy,
                                   output logic fired,
                                   output t_gesture_event ev);
        fired = 1'b0;
        ev    = make_event(EV_CLICK, anchor_x, anchor_y);
        case (gstate)
            GS_PRESSED: begin
                if (pen_up) begin
                    tick_cnt = TICK_W'(1);
                    if (tick_cnt >= window_lim) begin
                        gstate = GS_IDLE;
                        fired  = 1'b1;
                    end else begin
                        gstate = GS_RELEASED;
                    end
                end else begin
                    tick_cnt = tick_cnt + 1'b1;
                    if (tick_cnt >= hold_lim) begin
                        gstate  = GS_DRAG;
                        fired   = 1'b1;
                        ev.code = EV_DOWN;
                    end
                end
            end
            GS_RELEASED: begin
                if (!pen_up) begin
                    fired = 1'b1;
                    if (tick_cnt < min_gap) begin
                        // second press too soon: plain click
                        gstate = GS_IDLE;
                    end else begin
                        tick_cnt = '0;
                        gstate   = (lockout_lim == '0) ? GS_IDLE : GS_LOCKOUT;
                        ev.code  = EV_DOUBLE;
                    end
                end else begin
                    tick_cnt = tick_cnt + 1'b1;
                    if (tick_cnt >= window_lim) begin
                        gstate = GS_IDLE;
                        fired  = 1'b1;
                    end
                end
            end
            GS_LOCKOUT: begin
                tick_cnt = tick_cnt + 1'b1;
                if (tick_cnt >= lockout_lim) begin
                    gstate = GS_IDLE;
                end
            end
            GS_DRAG: begin
                if (pen_up) begin
                    gstate   = GS_IDLE;
                    anchor_x = sx;
                    anchor_y = sy;
                    fired    = 1'b1;
                    ev       = make_event(EV_UP, sx, sy);
                end else if (axis_dist(anchor_x, sx) > move_thresh ||
                             axis_dist(anchor_y, sy) > move_thresh) begin
                    anchor_x = sx;
                    anchor_y = sy;
                    fired    = 1'b1;
                    ev       = make_event(EV_MOVE, sx, sy);
                end
            end
            default: begin
                gstate = GS_IDLE;
                if (!pen_up) begin
                    // capture the press point; this is sample one of the hold
                    anchor_x = sx;
                    anchor_y = sy;
                    tick_cnt = TICK_W'(1);
                    if (tick_cnt >= hold_lim) begin
                        gstate = GS_DRAG;
                        fired  = 1'b1;
                        ev     = make_event(EV_DOWN, sx, sy);
                    end else begin
                        gstate = GS_PRESSED;
                    end
                end
            end
        endcase
    endtask

    always @(posedge i_clk) begin : watch
        logic               fired;
        t_gesture_event     ev;
        t_gesture_event     want;
        logic [COORD_W-1:0] got_x;
        logic [COORD_W-1:0] got_y;

        if (!i_rst_n) begin
            gstate      = GS_IDLE;
            tick_cnt    = '0;
            anchor_x    = '0;
            anchor_y    = '0;
            hold_lim    = HOLD_RST;
            window_lim  = SECOND_RST;
            min_gap     = MIN_GAP_RST;
            move_thresh = THRESH_RST;
            lockout_lim = LOCKOUT_RST;
            expected_events.delete();
        end else begin
            // compare an outgoing event with the oldest prediction
            if (i_evt_valid && i_evt_ready) begin
                got_x = i_evt_data[COORD_W-1:0];
                got_y = i_evt_data[2*COORD_W-1:COORD_W];
                if (expected_events.size() == 0) begin
                    report_mismatch($sformatf("unexpected event code %0d at (%0d,%0d)",
                                              i_evt_code, got_x, got_y));
                end else begin
                    want = expected_events.pop_front();
                    if (i_evt_code !== want.code)
                        report_mismatch($sformatf("code %0d, want %0d",
                                                  i_evt_code, want.code));
                    if (got_x !== want.x)
                        report_mismatch($sformatf("event_x %0d, want %0d (code %0d)",
                                                  got_x, want.x, want.code));
                    if (got_y !== want.y)
                        report_mismatch($sformatf("event_y %0d, want %0d (code %0d)",
                                                  got_y, want.y, want.code));
                end
            end

            // track register writes; narrow registers drop the upper bits
            if (i_cfg_wr_en) begin
                case (i_cfg_idx)
                    CFG_HOLD_TICKS:  hold_lim    = i_cfg_wdata[7:0];
                    CFG_SECOND_WIN:  window_lim  = i_cfg_wdata[7:0];
                    CFG_MIN_GAP:     min_gap     = i_cfg_wdata[7:0];
                    CFG_MOVE_THRESH: move_thresh = i_cfg_wdata[9:0];
                    CFG_LOCKOUT:     lockout_lim = i_cfg_wdata[9:0];
                    default: ;
                endcase
            end

            // predict from the accepted sample
            if (i_smp_valid && i_smp_ready) begin
                classify_sample(i_smp_pen_up, i_smp_data[COORD_W-1:0],
                                i_smp_data[2*COORD_W-1:COORD_W], fired, ev);
                if (fired)
                    expected_events.push_back(ev);
            end
        end
        o_pending = expected_events.size();
    end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import tgc_pkg::*;

    localparam int COORD_W     = 10;
    localparam int DATA_W      = ((2 * COORD_W + 7) / 8) * 8;
    localparam int COORD_MAX   = (1 << COORD_W) - 1;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_PAD   = 4;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic [DATA_W-1:0]     s_axis_tdata  = '0;
    logic                  s_axis_tuser  = 1'b0;
    logic                  m_axis_tready = 1'b0;
    logic                  cfg_wr_en     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx       = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata     = '0;

    wire                   s_axis_tready;
    wire                   m_axis_tvalid;
    wire  [DATA_W-1:0]     m_axis_tdata;
    wire  [EVENT_W-1:0]    m_axis_tuser;

    int mismatches;
    int pending;
    int send_idle_pct = 16;
    int recv_idle_pct = 75;
    int cycle_count   = 0;
    int sent_items    = 0;
    int pos_x;
    int pos_y;
    int hold_cfg;
    int window_cfg;
    int gap_cfg;
    int thresh_cfg;
    int lockout_cfg;

    touch_gesture_classifier #(
        .COORD_BITS(COORD_W)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_wdata  (cfg_wdata)
    );

    gesture_checker #(
        .COORD_W(COORD_W),
        .DATA_W (DATA_W)
    ) checker_u (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_smp_valid (s_axis_tvalid),
        .i_smp_ready (s_axis_tready),
        .i_smp_data  (s_axis_tdata),
        .i_smp_pen_up(s_axis_tuser),
        .i_evt_valid (m_axis_tvalid),
        .i_evt_ready (m_axis_tready),
        .i_evt_data  (m_axis_tdata),
        .i_evt_code  (m_axis_tuser),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata),
        .o_mismatches(mismatches),
        .o_pending   (pending)
    );

    always #6 i_clk = ~i_clk;

    // Stall the event side at random
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Send one sample request, with random gaps in front of it
    task automatic send_sample(input logic pen_up, input int x, input int y);
        logic [DATA_W-1:0] word;
        word                        = '0;
        word[COORD_W-1:0]           = x[COORD_W-1:0];
        word[2*COORD_W-1:COORD_W]   = y[COORD_W-1:0];
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= pen_up;
        s_axis_tdata  <= word;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        sent_items++;
    endtask

    // Hold off the sender until every predicted event is out
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_PAD) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= value;
        @(negedge i_clk);
        cfg_wr_en <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic program_regs(input int hold, input int window, input int gap,
                                input int thresh, input int lockout);
        settle();
        // junk in the upper bits of the 8-bit registers must be dropped
        write_reg(CFG_HOLD_TICKS, {2'($urandom), 8'(hold)});
        write_reg(CFG_SECOND_WIN, {2'($urandom), 8'(window)});
        write_reg(CFG_MIN_GAP, {2'($urandom), 8'(gap)});
        write_reg(CFG_MOVE_THRESH, 10'(thresh));
        write_reg(CFG_LOCKOUT, 10'(lockout));
        hold_cfg    = hold;
        window_cfg  = window;
        gap_cfg     = gap;
        thresh_cfg  = thresh;
        lockout_cfg = lockout;
    endtask

    function automatic int clamp_coord(input int c);
        return (c < 0) ? 0 : (c > COORD_MAX) ? COORD_MAX : c;
    endfunction

    function automatic int fresh_coord();
        case ($urandom_range(3))
            0: return 0;
            1: return COORD_MAX;
            default: return $urandom_range(COORD_MAX);
        endcase
    endfunction

    // Step a coordinate by about the move threshold, or jump anywhere
    function automatic int drift_coord(input int c, input int thresh);
        int delta;
        case ($urandom_range(5))
            0: delta = 0;
            1: delta = thresh;
            2: delta = thresh + 1;
            3: delta = $urandom_range(thresh);
            4: delta = $urandom_range(COORD_MAX);
            default: return fresh_coord();
        endcase
        if ($urandom_range(1) == 1)
            delta = -delta;
        return clamp_coord(c + delta);
    endfunction

    // Run length near a limit, so counters hit their boundaries
    function automatic int pick_len(input int limit);
        int n;
        case ($urandom_range(5))
            0: n = 1;
            1: n = limit - 1;
            2: n = limit;
            3: n = limit + 1;
            4: n = $urandom_range(limit + 2, 1);
            default: n = $urandom_range(3, 1);
        endcase
        return (n < 1) ? 1 : n;
    endfunction

    task automatic press_run(input int n);
        pos_x = fresh_coord();
        pos_y = fresh_coord();
        repeat (n) begin
            send_sample(1'b0, pos_x, pos_y);
            if ($urandom_range(1) == 1)
                pos_x = drift_coord(pos_x, thresh_cfg);
            if ($urandom_range(1) == 1)
                pos_y = drift_coord(pos_y, thresh_cfg);
        end
    endtask

    task automatic lift_run(input int n);
        repeat (n) send_sample(1'b1, $urandom_range(COORD_MAX), $urandom_range(COORD_MAX));
    endtask

    task automatic noise_run(input int n);
        repeat (n) begin
            send_sample(1'($urandom_range(1)), $urandom_range(COORD_MAX),
                        $urandom_range(COORD_MAX));
        end
    endtask

    // Mostly well-formed taps, double taps and drags, some noise
    task automatic gesture_mix(input int target);
        int stop_at;
        stop_at = sent_items + target;
        while (sent_items < stop_at) begin
            case ($urandom_range(9))
                0, 1, 2: begin
                    press_run(pick_len(hold_cfg));
                    lift_run(pick_len(window_cfg));
                end
                3, 4: begin
                    press_run(pick_len(hold_cfg));
                    lift_run(pick_len(gap_cfg));
                    press_run(pick_len(2));
                    lift_run(pick_len(lockout_cfg));
                end
                5, 6, 7: begin
                    press_run(hold_cfg + $urandom_range(12));
                    lift_run($urandom_range(3, 1));
                end
                default: noise_run($urandom_range(6, 1));
            endcase
        end
    endtask

    task automatic random_setup();
        int thresh;
        case ($urandom_range(5))
            0: thresh = 0;
            1: thresh = COORD_MAX;
            default: thresh = $urandom_range(60, 1);
        endcase
        program_regs($urandom_range(16, 1), $urandom_range(20, 1), $urandom_range(12, 0),
                     thresh, $urandom_range(15, 0));
    endtask

    // Run length guard
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAIL touch_gesture_classifier");
        $finish;
    end

    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // hold of one: DOWN on the press sample, MOVE on any change, then UP
        program_regs(1, 1, 0, 0, 0);
        send_sample(1'b0, 0, 0);
        send_sample(1'b0, 0, 0);
        send_sample(1'b0, COORD_MAX, COORD_MAX);
        send_sample(1'b1, 512, 3);

        // window of one: the release sample itself gives CLICK
        program_regs(2, 1, 0, COORD_MAX, 0);
        send_sample(1'b0, 5, 6);
        send_sample(1'b1, 0, 0);
        // full-axis jump does not exceed the largest threshold
        send_sample(1'b0, 0, COORD_MAX);
        send_sample(1'b0, 0, COORD_MAX);
        send_sample(1'b0, COORD_MAX, 0);
        send_sample(1'b1, COORD_MAX, COORD_MAX);

        // early second press, then a new press, then a double click
        program_regs(3, 4, 2, 1, 0);
        send_sample(1'b0, 100, 200);
        send_sample(1'b1, 101, 201);
        send_sample(1'b0, 102, 202);
        send_sample(1'b0, 300, 400);
        send_sample(1'b1, 301, 401);
        send_sample(1'b1, 302, 402);
        send_sample(1'b0, 303, 403);
        // no second press: CLICK when the window runs out
        send_sample(1'b0, 7, 8);
        lift_run(4);

        // lower the hold limit in the middle of a press
        send_sample(1'b0, 600, 601);
        settle();
        write_reg(CFG_HOLD_TICKS, 10'd1);
        hold_cfg = 1;
        send_sample(1'b0, 602, 601);
        send_sample(1'b0, 604, 601);
        send_sample(1'b1, 9, 9);

        // double click followed by a short lockout
        program_regs(3, 4, 0, 1, 2);
        send_sample(1'b0, 40, 50);
        send_sample(1'b1, 41, 51);
        send_sample(1'b0, 42, 52);
        send_sample(1'b0, 43, 53);
        send_sample(1'b0, 44, 54);
        send_sample(1'b1, 45, 55);

        // indexes past the last register must leave everything alone
        settle();
        for (int i = CFG_LOCKOUT + 1; i < (1 << CFG_IDX_W); i++)
            write_reg(CFG_IDX_W'(i), 10'($urandom));
        send_sample(1'b0, 11, 12);
        send_sample(1'b1, 13, 14);
        lift_run(4);

        // largest hold and window limits: long hold, full window, long lockout
        send_idle_pct = 16;
        recv_idle_pct = 75;
        program_regs(255, 255, 0, COORD_MAX, 300);
        press_run(258);
        lift_run(1);
        press_run(2);
        lift_run(255);
        press_run(2);
        lift_run(1);
        press_run(1);
        noise_run(300);
        lift_run(1);

        // largest minimum gap: any second press is a plain click
        program_regs(2, 255, 255, 0, 0);
        press_run(1);
        lift_run(5);
        press_run(1);
        press_run(6);
        lift_run(1);

        // random gestures over changing settings and idle patterns
        for (int ph = 0; ph < 6; ph++) begin
            case (ph / 2)
                0: begin
                    send_idle_pct = 16;
                    recv_idle_pct = 75;
                end
                1: begin
                    send_idle_pct = 75;
                    recv_idle_pct = 16;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            random_setup();
            gesture_mix(20);
        end

        settle();
        repeat (8) @(negedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("PASS touch_gesture_classifier");
        end else begin
            $display("FAIL touch_gesture_classifier");
        end
        $finish;
    end

endmodule
